/* hdl/rpb_pkg.sv */
// rpb_pkg: shared types, codes and helpers for the rgb555 pixel blender
// no dependencies; used by rpb_chan and rgb555_pixel_blend_top
`timescale 1ns / 1ps
`default_nettype none

package rpb_pkg;

    typedef enum logic [2:0] {
        MODE_COPY  = 3'd0,
        MODE_BGRX  = 3'd1,
        MODE_BGRA  = 3'd2,
        MODE_WHITE = 3'd3,
        MODE_TINT  = 3'd4,
        MODE_FIXED = 3'd5
    } mode_t;

    localparam logic [2:0] REG_MODE        = 3'd0;
    localparam logic [2:0] REG_TINT_PACKED = 3'd1;
    localparam logic [2:0] REG_TINT_ALPHA  = 3'd2;
    localparam logic [2:0] REG_TINT_LINEAR = 3'd3;
    localparam logic [2:0] REG_FIXED_BG    = 3'd4;

    localparam logic [16:0] FULL_ALPHA   = 17'h10000;
    localparam logic [12:0] TINT_OPAQUE  = 13'd4096;
    localparam logic [4:0]  CH_MAX       = 5'd31;
    localparam logic [7:0]  COVER_MAX    = 8'd255;

    localparam logic [14:0] TINT_PACKED_RST = 15'h7FFF;
    localparam logic [38:0] TINT_LINEAR_RST = 39'h40_0200_1000;

    typedef struct packed {
        logic prod_en;
        logic sum_en;
    } stage_en_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

    // floor(a * 65536 / 255) = a * 257 + (a == 255)
    function automatic logic [16:0] cover_alpha(input logic [7:0] a8);
        return (a8 == COVER_MAX) ? FULL_ALPHA : {1'b0, a8, a8};
    endfunction

endpackage

`default_nettype wire

/* hdl/rpb_chan.sv */
// rpb_chan: one color channel of the blend, product stage and sum stage
// depends on rpb_pkg
`timescale 1ns / 1ps
`default_nettype none

module rpb_chan (
    input  wire logic              aclk,
    input  wire rpb_pkg::stage_en_t en,
    input  wire logic              fixed_in,
    input  wire logic [12:0]       d_in,
    input  wire logic [12:0]       f_in,
    input  wire logic [16:0]       inv_in,
    input  wire logic [16:0]       w_in,
    output logic      [4:0]        ch_out
);

    logic [29:0] prod_d_reg;
    logic [29:0] prod_f_reg;
    logic        fixed_reg;
    logic [4:0]  ch_reg;

    logic [30:0] sum_next;
    logic [15:0] shifted_next;
    logic [4:0]  ch_next;

    always_ff @(posedge aclk) begin
        if (en.prod_en) begin
            prod_d_reg <= 30'(d_in) * 30'(inv_in);
            prod_f_reg <= 30'(f_in) * 30'(w_in);
            fixed_reg  <= fixed_in;
        end
    end

    always_comb begin
        sum_next     = 31'(prod_d_reg) + 31'(prod_f_reg);
        shifted_next = fixed_reg ? sum_next[30:15] : {1'b0, sum_next[30:16]};
        if (fixed_reg && (|shifted_next[15:5])) begin
            ch_next = rpb_pkg::CH_MAX;
        end else begin
            ch_next = shifted_next[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.sum_en) begin
            ch_reg <= ch_next;
        end
    end

    assign ch_out = ch_reg;

endmodule

`default_nettype wire

/* hdl/rgb555_pixel_blend_top.sv */
// rgb555_pixel_blend_top: four-stage pixel blender for byte-swapped 5-5-5 pixels
// each accepted input word passes stages 1 to 4 in turn to its result word, one word per cycle unless m_ready stalls
// stage 2 holds the alpha scale multiply, stage 3 the per-channel multiplies
// reset: synchronous active-low aresetn empties the pipeline, config gets defaults
// depends on rpb_pkg and rpb_chan
`timescale 1ns / 1ps
`default_nettype none

module rgb555_pixel_blend_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_index,
    input  wire logic [38:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_source_word,
    input  wire logic [15:0] s_destination_pixel,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [15:0] m_result_pixel
);

    // config registers
    logic [2:0]  mode_reg;
    logic [14:0] tint_packed_reg;
    logic [12:0] tint_alpha_reg;
    logic [38:0] tint_linear_reg;
    logic [38:0] fixed_bg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= 3'(rpb_pkg::MODE_COPY);
            tint_packed_reg <= rpb_pkg::TINT_PACKED_RST;
            tint_alpha_reg  <= rpb_pkg::TINT_OPAQUE;
            tint_linear_reg <= rpb_pkg::TINT_LINEAR_RST;
            fixed_bg_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                rpb_pkg::REG_MODE:        mode_reg        <= cfg_wr_data[2:0];
                rpb_pkg::REG_TINT_PACKED: tint_packed_reg <= cfg_wr_data[14:0];
                rpb_pkg::REG_TINT_ALPHA:  tint_alpha_reg  <= cfg_wr_data[12:0];
                rpb_pkg::REG_TINT_LINEAR: tint_linear_reg <= cfg_wr_data;
                rpb_pkg::REG_FIXED_BG:    fixed_bg_reg    <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: input capture, coverage, direct results
    logic [2:0]  mode1_reg;
    logic [31:0] src1_reg;
    logic [15:0] back1_reg;
    logic [16:0] cov1_reg;
    logic [15:0] direct1_reg;
    logic        use_dir1_reg;

    logic [16:0] cov1_next;
    logic [15:0] direct1_next;
    logic        use_dir1_next;

    always_comb begin
        if (mode_reg == 3'(rpb_pkg::MODE_BGRA)) begin
            cov1_next = rpb_pkg::cover_alpha(s_source_word[31:24]);
        end else begin
            cov1_next = rpb_pkg::cover_alpha(s_source_word[7:0]);
        end
        unique case (mode_reg)
            3'(rpb_pkg::MODE_COPY): begin
                direct1_next  = s_source_word[15:0];
                use_dir1_next = 1'b1;
            end
            3'(rpb_pkg::MODE_BGRX): begin
                direct1_next  = rpb_pkg::swap16({s_source_word[7:3], s_source_word[15:11],
                                                 1'b0, s_source_word[23:19]});
                use_dir1_next = 1'b1;
            end
            3'(rpb_pkg::MODE_BGRA), 3'(rpb_pkg::MODE_WHITE),
            3'(rpb_pkg::MODE_TINT), 3'(rpb_pkg::MODE_FIXED): begin
                direct1_next  = '0;
                use_dir1_next = 1'b0;
            end
            default: begin
                direct1_next  = '0;
                use_dir1_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mode1_reg    <= mode_reg;
            src1_reg     <= s_source_word;
            back1_reg    <= rpb_pkg::swap16(s_destination_pixel);
            cov1_reg     <= cov1_next;
            direct1_reg  <= direct1_next;
            use_dir1_reg <= use_dir1_next;
        end
    end

    // stage 2: alpha scaling by tint alpha in tint and fixed modes
    logic [2:0]  mode2_reg;
    logic [23:0] src2_reg;
    logic [15:0] back2_reg;
    logic [16:0] a2_reg;
    logic [15:0] direct2_reg;
    logic        use_dir2_reg;

    logic [12:0] tint_alpha_cl;
    logic [16:0] mult_a;
    logic [29:0] prod2;
    logic [16:0] a2_next;

    always_comb begin
        tint_alpha_cl = (tint_alpha_reg > rpb_pkg::TINT_OPAQUE) ? rpb_pkg::TINT_OPAQUE
                                                                : tint_alpha_reg;
        mult_a = (mode1_reg == 3'(rpb_pkg::MODE_FIXED)) ? {9'd0, src1_reg[7:0]} : cov1_reg;
        prod2  = 30'(mult_a) * 30'(tint_alpha_cl);
        if (mode1_reg == 3'(rpb_pkg::MODE_TINT) || mode1_reg == 3'(rpb_pkg::MODE_FIXED)) begin
            a2_next = prod2[28:12];
        end else begin
            a2_next = cov1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            mode2_reg    <= mode1_reg;
            src2_reg     <= src1_reg[23:0];
            back2_reg    <= back1_reg;
            a2_reg       <= a2_next;
            direct2_reg  <= direct1_reg;
            use_dir2_reg <= use_dir1_reg;
        end
    end

    // stage 3 operands, stages 3 and 4 in the channel units
    logic        fixed2;
    logic [16:0] inv2;
    logic [16:0] w2;
    logic [12:0] d_r, d_g, d_b;
    logic [12:0] f_r, f_g, f_b;

    always_comb begin
        fixed2 = (mode2_reg == 3'(rpb_pkg::MODE_FIXED));
        inv2   = fixed2 ? 17'(rpb_pkg::COVER_MAX - a2_reg[7:0]) : rpb_pkg::FULL_ALPHA - a2_reg;
        w2     = (mode2_reg == 3'(rpb_pkg::MODE_BGRA)) ? {3'd0, a2_reg[16:3]} : a2_reg;
        if (fixed2) begin
            d_r = fixed_bg_reg[38:26];
            d_g = fixed_bg_reg[25:13];
            d_b = fixed_bg_reg[12:0];
        end else begin
            d_r = {8'd0, back2_reg[4:0]};
            d_g = {8'd0, back2_reg[10:6]};
            d_b = {8'd0, back2_reg[15:11]};
        end
        unique case (mode2_reg)
            3'(rpb_pkg::MODE_BGRA): begin
                f_r = {5'd0, src2_reg[23:16]};
                f_g = {5'd0, src2_reg[15:8]};
                f_b = {5'd0, src2_reg[7:0]};
            end
            3'(rpb_pkg::MODE_WHITE): begin
                f_r = {8'd0, rpb_pkg::CH_MAX};
                f_g = {8'd0, rpb_pkg::CH_MAX};
                f_b = {8'd0, rpb_pkg::CH_MAX};
            end
            3'(rpb_pkg::MODE_TINT): begin
                f_r = {8'd0, tint_packed_reg[14:10]};
                f_g = {8'd0, tint_packed_reg[9:5]};
                f_b = {8'd0, tint_packed_reg[4:0]};
            end
            3'(rpb_pkg::MODE_FIXED): begin
                f_r = tint_linear_reg[38:26];
                f_g = tint_linear_reg[25:13];
                f_b = tint_linear_reg[12:0];
            end
            default: begin
                f_r = '0;
                f_g = '0;
                f_b = '0;
            end
        endcase
    end

    rpb_pkg::stage_en_t chan_en;
    assign chan_en.prod_en = rdy3;
    assign chan_en.sum_en  = rdy4;

    logic [4:0] ch_r, ch_g, ch_b;

    rpb_chan u_chan_r (
        .aclk     (aclk),
        .en       (chan_en),
        .fixed_in (fixed2),
        .d_in     (d_r),
        .f_in     (f_r),
        .inv_in   (inv2),
        .w_in     (w2),
        .ch_out   (ch_r)
    );

    rpb_chan u_chan_g (
        .aclk     (aclk),
        .en       (chan_en),
        .fixed_in (fixed2),
        .d_in     (d_g),
        .f_in     (f_g),
        .inv_in   (inv2),
        .w_in     (w2),
        .ch_out   (ch_g)
    );

    rpb_chan u_chan_b (
        .aclk     (aclk),
        .en       (chan_en),
        .fixed_in (fixed2),
        .d_in     (d_b),
        .f_in     (f_b),
        .inv_in   (inv2),
        .w_in     (w2),
        .ch_out   (ch_b)
    );

    logic [15:0] direct3_reg, direct4_reg;
    logic        use_dir3_reg, use_dir4_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            direct3_reg  <= direct2_reg;
            use_dir3_reg <= use_dir2_reg;
        end
        if (rdy4) begin
            direct4_reg  <= direct3_reg;
            use_dir4_reg <= use_dir3_reg;
        end
    end

    assign m_result_pixel = use_dir4_reg ? direct4_reg
                                         : rpb_pkg::swap16({ch_b, ch_g, 1'b0, ch_r});

    // checks
    a_stall_only_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output not blocked");

    a_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (a2_reg <= rpb_pkg::FULL_ALPHA))
        else $error("scaled alpha above full");

    a_fixed_alpha_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && fixed2) |-> (a2_reg <= 17'(rpb_pkg::COVER_MAX)))
        else $error("fixed blend alpha above 255");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* verif/rgb555_pixel_checker.sv */
// rgb555_pixel_checker: follows the config port and both word channels of the pixel blender,
// works out every result pixel from its own copy of the registers and compares in order
// depends on rpb_pkg for mode codes, register indexes and reset values
`timescale 1ns / 1ps

module rgb555_pixel_checker
    import rpb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_wr_index,
    input  wire logic [38:0] cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_source_word,
    input  wire logic [15:0] s_destination_pixel,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_result_pixel,
    output int               fail_count,
    output int               pending,
    output int               words_checked
);

    logic [2:0]  mode_reg;
    logic [14:0] tint_packed_reg;
    logic [12:0] tint_alpha_reg;
    logic [38:0] tint_linear_reg;
    logic [38:0] fixed_bg_reg;

    logic [15:0] expected_pixels[$];
    logic [15:0] want;
    int          errors;
    int          checked;

    // 8-bit coverage to 1.16 scale, floor(a * 65536 / 255)
    function automatic int unsigned scale_alpha(input logic [7:0] a8);
        return (32'(a8) * 32'(FULL_ALPHA)) / 32'd255;
    endfunction

    function automatic logic [15:0] pack_pixel(input int unsigned r, input int unsigned g,
                                               input int unsigned b);
        logic [15:0] w;
        w = {b[4:0], g[4:0], 1'b0, r[4:0]};
        return {w[7:0], w[15:8]};
    endfunction

    function automatic int unsigned mix_linear(input int unsigned bg, input int unsigned fg,
                                               input int unsigned a, input int unsigned inv);
        int unsigned v;
        v = (bg * inv + fg * a) >> 15;
        return (v > CH_MAX) ? CH_MAX : v;
    endfunction

    function automatic logic [15:0] blend_pixel(input logic [31:0] src, input logic [15:0] dst);
        logic [15:0] back;
        int unsigned dr, dg, db, a, inv, s, ta;
        back = {dst[7:0], dst[15:8]};
        dr = back[4:0];
        dg = back[10:6];
        db = back[15:11];
        ta = (tint_alpha_reg > TINT_OPAQUE) ? TINT_OPAQUE : tint_alpha_reg;
        case (mode_reg)
            MODE_COPY: begin
                return src[15:0];
            end
            MODE_BGRX: begin
                return pack_pixel(src[23:19], src[15:11], src[7:3]);
            end
            MODE_BGRA: begin
                a = scale_alpha(src[31:24]);
                inv = FULL_ALPHA - a;
                s = a >> 3;
                return pack_pixel((dr * inv + src[23:16] * s) >> 16,
                                  (dg * inv + src[15:8] * s) >> 16,
                                  (db * inv + src[7:0] * s) >> 16);
            end
            MODE_WHITE: begin
                a = scale_alpha(src[7:0]);
                inv = FULL_ALPHA - a;
                return pack_pixel((dr * inv + CH_MAX * a) >> 16,
                                  (dg * inv + CH_MAX * a) >> 16,
                                  (db * inv + CH_MAX * a) >> 16);
            end
            MODE_TINT: begin
                a = (scale_alpha(src[7:0]) * ta) >> 12;
                inv = FULL_ALPHA - a;
                return pack_pixel((dr * inv + tint_packed_reg[14:10] * a) >> 16,
                                  (dg * inv + tint_packed_reg[9:5] * a) >> 16,
                                  (db * inv + tint_packed_reg[4:0] * a) >> 16);
            end
            MODE_FIXED: begin
                a = (ta * src[7:0]) / TINT_OPAQUE;
                inv = COVER_MAX - a;
                return pack_pixel(mix_linear(fixed_bg_reg[38:26], tint_linear_reg[38:26], a, inv),
                                  mix_linear(fixed_bg_reg[25:13], tint_linear_reg[25:13], a, inv),
                                  mix_linear(fixed_bg_reg[12:0], tint_linear_reg[12:0], a, inv));
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg = MODE_COPY;
            tint_packed_reg = TINT_PACKED_RST;
            tint_alpha_reg = TINT_OPAQUE;
            tint_linear_reg = TINT_LINEAR_RST;
            fixed_bg_reg = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_MODE:        mode_reg = cfg_wr_data[2:0];
                    REG_TINT_PACKED: tint_packed_reg = cfg_wr_data[14:0];
                    REG_TINT_ALPHA:  tint_alpha_reg = cfg_wr_data[12:0];
                    REG_TINT_LINEAR: tint_linear_reg = cfg_wr_data;
                    REG_FIXED_BG:    fixed_bg_reg = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result_pixel: unexpected word %h with nothing pending", m_result_pixel);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    checked++;
                    if (m_result_pixel !== want) begin
                        $error("result_pixel: expected %h, actual %h", want, m_result_pixel);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_pixels.push_back(blend_pixel(s_source_word, s_destination_pixel));
        end
        fail_count <= errors;
        pending <= expected_pixels.size();
        words_checked <= checked;
    end

endmodule

/* verif/tb.sv */
// tb: drives the rgb555 pixel blender with directed and random pixel words under several
// register settings, with random stalls on both channels; verdict from rgb555_pixel_checker
// depends on rpb_pkg, rgb555_pixel_blend_top and rgb555_pixel_checker
`timescale 1ns / 1ps

module tb;
    import rpb_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD = 48;
    localparam int PHASES = 24;
    localparam int WORDS_PER_PHASE = 50;
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [38:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_source_word = '0;
    logic [15:0] s_destination_pixel = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_result_pixel;

    int fail_count;
    int pending;
    int words_checked;
    int settings_used;
    int quiet_cycles;
    bit idle_on = 1'b1;
    bit hold_off_req = 1'b0;

    always #5 aclk = ~aclk;

    rgb555_pixel_blend_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_source_word       (s_source_word),
        .s_destination_pixel (s_destination_pixel),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_pixel      (m_result_pixel)
    );

    rgb555_pixel_checker pixel_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_index        (cfg_wr_index),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_source_word       (s_source_word),
        .s_destination_pixel (s_destination_pixel),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_result_pixel      (m_result_pixel),
        .fail_count          (fail_count),
        .pending             (pending),
        .words_checked       (words_checked)
    );

    function automatic logic [38:0] pick_linear();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return TINT_LINEAR_RST;
            1: return '0;
            2: return '1;
            3: return {13'($urandom_range(0, 4096)), 13'($urandom_range(0, 4096)),
                       13'($urandom_range(0, 4096))};
            default: return r[38:0];
        endcase
    endfunction

    task automatic put_word(input logic [31:0] src, input logic [15:0] dst);
        int gap;
        gap = (idle_on && !hold_off_req && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_source_word <= src;
        s_destination_pixel <= dst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // register writes back to back, plus one write to a spare index that must be ignored
    task automatic set_blend_regs(input logic [2:0] m, input logic [14:0] tp,
                                  input logic [12:0] ta, input logic [38:0] tl,
                                  input logic [38:0] fb);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= REG_MODE;
        cfg_wr_data <= {junk[38:3], m};
        @(posedge aclk);
        cfg_wr_index <= REG_TINT_PACKED;
        cfg_wr_data <= {junk[38:15], tp};
        @(posedge aclk);
        cfg_wr_index <= REG_TINT_ALPHA;
        cfg_wr_data <= {junk[38:13], ta};
        @(posedge aclk);
        cfg_wr_index <= REG_TINT_LINEAR;
        cfg_wr_data <= tl;
        @(posedge aclk);
        cfg_wr_index <= REG_FIXED_BG;
        cfg_wr_data <= fb;
        @(posedge aclk);
        cfg_wr_index <= REG_FIXED_BG + 3'($urandom_range(1, 3));
        cfg_wr_data <= junk[38:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // receiver side: ready bursts, stall bursts, and one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [2:0]  m;
        logic [12:0] ta;
        logic [14:0] tp;
        logic [31:0] src;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: copy
        put_word(32'h0000_0000, 16'h0000);
        put_word(32'hFFFF_FFFF, 16'hFFFF);
        put_word(32'h1234_A5A5, 16'h5A5A);
        drain();

        set_blend_regs(MODE_BGRX, TINT_PACKED_RST, TINT_OPAQUE, TINT_LINEAR_RST, '0);
        put_word(32'hFFFF_FFFF, 16'h0000);
        put_word(32'h00F8_F8F8, 16'hFFFF);
        drain();

        // transparent, opaque and half source alpha
        set_blend_regs(MODE_BGRA, TINT_PACKED_RST, TINT_OPAQUE, TINT_LINEAR_RST, '0);
        put_word(32'h00FF_FFFF, 16'hFFFF);
        put_word(32'hFF00_0000, 16'hFFFF);
        put_word(32'h80FF_8040, 16'h20F7);
        drain();

        // destination unused bit set must not leak through
        set_blend_regs(MODE_WHITE, TINT_PACKED_RST, TINT_OPAQUE, TINT_LINEAR_RST, '0);
        put_word(32'h0000_0000, 16'h2000);
        put_word(32'hFFFF_FFFF, 16'h0000);
        put_word(32'h0000_0080, 16'hFFFF);
        drain();

        // tint alpha above opaque, then fully transparent black tint
        set_blend_regs(MODE_TINT, TINT_PACKED_RST, 13'h1FFF, TINT_LINEAR_RST, '0);
        put_word(32'h0000_00FF, 16'hFFFF);
        put_word(32'h0000_0001, 16'h0000);
        drain();
        set_blend_regs(MODE_TINT, '0, '0, TINT_LINEAR_RST, '0);
        put_word(32'h0000_00FF, 16'hFFFF);
        drain();

        // linear channels at maximum saturate
        set_blend_regs(MODE_FIXED, TINT_PACKED_RST, TINT_OPAQUE, '1, '1);
        put_word(32'h0000_00FF, 16'h0000);
        put_word(32'hFFFF_FF00, 16'hFFFF);
        drain();
        set_blend_regs(MODE_FIXED, TINT_PACKED_RST, 13'h1FFF, TINT_LINEAR_RST, '0);
        put_word(32'h0000_0080, 16'h0000);
        drain();

        set_blend_regs(MODE_SPARE_A, TINT_PACKED_RST, TINT_OPAQUE, TINT_LINEAR_RST, '0);
        put_word(32'hFFFF_FFFF, 16'hFFFF);
        drain();
        set_blend_regs(MODE_SPARE_B, TINT_PACKED_RST, TINT_OPAQUE, TINT_LINEAR_RST, '0);
        put_word(32'hFFFF_FFFF, 16'hFFFF);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph < PHASES - 4);
            m = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0: ta = TINT_OPAQUE;
                1: ta = 13'($urandom_range(0, 4096));
                2: ta = 13'($urandom);
                default: ta = $urandom_range(0, 1) ? 13'h1FFF : 13'h0000;
            endcase
            if ($urandom_range(0, 3) == 0)
                tp = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
            else
                tp = 15'($urandom);
            set_blend_regs(m, tp, ta, pick_linear(), pick_linear());
            if (ph == 5)
                hold_off_req = 1'b1;
            repeat (WORDS_PER_PHASE) begin
                src = $urandom;
                case ($urandom_range(0, 3))
                    0: src[31:24] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    1: src[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: ;
                endcase
                put_word(src, 16'($urandom));
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        $display("%0d pixel words compared over %0d register settings", words_checked,
                 settings_used);
        $display("all six blend modes and both spare mode codes, with stalls on both sides");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
